// ===== rtl/elgamal_sign_verify_assert.svh =====
// assertion macros used by the elgamal sign and verify controller
`ifndef ELGAMAL_SIGN_VERIFY_ASSERT_SVH
`define ELGAMAL_SIGN_VERIFY_ASSERT_SVH

// checked on every clock edge outside reset
`define EGSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every clock edge, reset included
`define EGSV_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/egsv_pkg.sv =====
// shared types and constants of the elgamal sign and verify block
`timescale 1ns / 1ps
package egsv_pkg;

  localparam int MSG_W     = 16;
  localparam int OUT_W     = 16;
  localparam int CFG_IDX_W = 8;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIV_KEY  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE     = 8'd3;

  // register values after reset
  localparam int MODULUS_RST   = 23;
  localparam int GENERATOR_RST = 5;
  localparam int PRIV_KEY_RST  = 3;
  localparam int NONCE_RST     = 5;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL, OP_DIV, OP_EXP_LOAD, OP_EXP_SHIFT, OP_COPY,
    OP_EUC_INIT, OP_EUC_STEP, OP_DIFF, OP_FAIL, OP_DEGEN, OP_CHECK, OP_PUBLISH
  } dp_op_e;

  typedef enum logic [4:0] {
    SRC_ONE, SRC_GEN, SRC_KEY, SRC_NONCE, SRC_MSG, SRC_GRED, SRC_Y, SRC_R,
    SRC_RN, SRC_DIFF, SRC_S, SRC_S0, SRC_S1, SRC_Q, SRC_ACC, SRC_BASE, SRC_LHS
  } src_e;

  typedef enum logic [3:0] {
    DST_GRED, DST_Y, DST_R, DST_KRED, DST_RN, DST_XR, DST_MM, DST_S, DST_T,
    DST_LHS, DST_ACC
  } dst_e;

  typedef struct packed {
    dp_op_e op;
    src_e   a_sel;
    src_e   b_sel;
    logic   use_n;
    dst_e   dst;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic exp_msb;
    logic r1_zero;
    logic r0_one;
    logic p_small;
  } dp_sts_t;

endpackage

// ===== rtl/egsv_dpath.sv =====
// datapath: configuration, work registers, modular multiplier and divider
`timescale 1ns / 1ps
module egsv_dpath import egsv_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WIDTH-1:0]     cfg_data_i,
  input  logic [MSG_W-1:0]     msg_i,
  input  dp_cmd_t              cmd_i,
  output dp_sts_t              sts_o,
  output logic [WIDTH-1:0]     y_o,
  output logic [WIDTH-1:0]     r_o,
  output logic [WIDTH-1:0]     s_o,
  output logic                 valid_o,
  output logic                 status_o
);

  localparam int OW  = (WIDTH > MSG_W) ? WIDTH : MSG_W;
  localparam int CW  = $clog2(OW);
  localparam int DCW = $clog2(WIDTH);

  // configuration registers
  logic [WIDTH-1:0] mod_q, gen_q, key_q, nonce_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q   <= WIDTH'(MODULUS_RST);
      gen_q   <= WIDTH'(GENERATOR_RST);
      key_q   <= WIDTH'(PRIV_KEY_RST);
      nonce_q <= WIDTH'(NONCE_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MODULUS:   mod_q   <= cfg_data_i;
        CFG_GENERATOR: gen_q   <= cfg_data_i;
        CFG_PRIV_KEY:  key_q   <= cfg_data_i;
        CFG_NONCE:     nonce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // work registers
  logic [MSG_W-1:0] msg_q;
  logic [WIDTH-1:0] n_q, gred_q, y_q, r_q, rn_q, xr_q, mm_q, diff_q, s_q, t_q;
  logic [WIDTH-1:0] lhs_q, acc_q, base_q;
  logic [OW-1:0]    exp_q;
  logic [WIDTH-1:0] e_r0_q, e_r1_q, e_s0_q, e_s1_q;
  logic             wval_q, wstat_q;
  logic [WIDTH-1:0] oy_q, or_q, os_q;
  logic             oval_q, ostat_q;

  // multiplier and divider
  logic             mb_q, db_q;
  logic [CW-1:0]    mcnt_q;
  logic [DCW-1:0]   dcnt_q;
  logic [WIDTH-1:0] ma_q, mmod_q, macc_q;
  logic [OW-1:0]    mbits_q;
  dst_e             mdst_q;
  logic [WIDTH-1:0] dquo_q, drem_q;

  // a - b modulo n for a, b below n
  function automatic logic [WIDTH-1:0] sub_mod(input logic [WIDTH-1:0] a,
                                               input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] n);
    logic [WIDTH:0] d;
    if (a >= b) d = {1'b0, a} - {1'b0, b};
    else        d = {1'b0, a} + {1'b0, n} - {1'b0, b};
    return d[WIDTH-1:0];
  endfunction

  // operand source selection
  function automatic logic [OW-1:0] src_val(input src_e sel);
    logic [OW-1:0] v;
    case (sel)
      SRC_ONE:   v = OW'(1);
      SRC_GEN:   v = OW'(gen_q);
      SRC_KEY:   v = OW'(key_q);
      SRC_NONCE: v = OW'(nonce_q);
      SRC_MSG:   v = OW'(msg_q);
      SRC_GRED:  v = OW'(gred_q);
      SRC_Y:     v = OW'(y_q);
      SRC_R:     v = OW'(r_q);
      SRC_RN:    v = OW'(rn_q);
      SRC_DIFF:  v = OW'(diff_q);
      SRC_S:     v = OW'(s_q);
      SRC_S0:    v = OW'(e_s0_q);
      SRC_S1:    v = OW'(e_s1_q);
      SRC_Q:     v = OW'(dquo_q);
      SRC_ACC:   v = OW'(acc_q);
      SRC_BASE:  v = OW'(base_q);
      SRC_LHS:   v = OW'(lhs_q);
      default:   v = '0;
    endcase
    return v;
  endfunction

  logic [OW-1:0]    a_full, b_val;
  logic [WIDTH-1:0] a_val;

  always_comb begin
    a_full = src_val(cmd_i.a_sel);
    b_val  = src_val(cmd_i.b_sel);
    a_val  = a_full[WIDTH-1:0];
  end

  // one multiplier bit: double, reduce, add, reduce
  logic [WIDTH:0]   m_dbl, m_red, m_sum;
  logic [WIDTH-1:0] m_next;
  logic             mul_fin;

  always_comb begin
    m_dbl   = {macc_q, 1'b0};
    m_red   = (m_dbl >= {1'b0, mmod_q}) ? m_dbl - {1'b0, mmod_q} : m_dbl;
    m_sum   = m_red + (mbits_q[OW-1] ? {1'b0, ma_q} : '0);
    m_next  = (m_sum >= {1'b0, mmod_q}) ? WIDTH'(m_sum - {1'b0, mmod_q})
                                        : m_sum[WIDTH-1:0];
    mul_fin = mb_q && (mcnt_q == CW'(OW - 1));
  end

  // one restoring divider bit
  logic [WIDTH:0]   d_sh;
  logic             d_ge;
  logic [WIDTH-1:0] d_rem;
  logic             div_fin;

  always_comb begin
    d_sh    = {drem_q, dquo_q[WIDTH-1]};
    d_ge    = d_sh >= {1'b0, e_r1_q};
    d_rem   = d_ge ? WIDTH'(d_sh - {1'b0, e_r1_q}) : d_sh[WIDTH-1:0];
    div_fin = db_q && (dcnt_q == DCW'(WIDTH - 1));
  end

  // destination write: a finished product or an accumulator copy
  logic             wr_en;
  dst_e             wr_dst;
  logic [WIDTH-1:0] wr_val;

  always_comb begin
    wr_en  = 1'b0;
    wr_dst = mdst_q;
    wr_val = m_next;
    if (mul_fin) begin
      wr_en = 1'b1;
    end else if (cmd_i.op == OP_COPY) begin
      wr_en  = 1'b1;
      wr_dst = cmd_i.dst;
      wr_val = acc_q;
    end
  end

  // busy flags and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mb_q   <= 1'b0;
      db_q   <= 1'b0;
      mcnt_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.op == OP_MUL) begin
        mb_q   <= 1'b1;
        mcnt_q <= '0;
      end else if (mb_q) begin
        mcnt_q <= mcnt_q + CW'(1);
        if (mul_fin) mb_q <= 1'b0;
      end
      if (cmd_i.op == OP_DIV) begin
        db_q   <= 1'b1;
        dcnt_q <= '0;
      end else if (db_q) begin
        dcnt_q <= dcnt_q + DCW'(1);
        if (div_fin) db_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (mb_q) begin
      macc_q  <= m_next;
      mbits_q <= {mbits_q[OW-2:0], 1'b0};
    end
    if (db_q) begin
      drem_q <= d_rem;
      dquo_q <= {dquo_q[WIDTH-2:0], d_ge};
    end
    if (wr_en) begin
      case (wr_dst)
        DST_GRED: gred_q <= wr_val;
        DST_Y:    y_q    <= wr_val;
        DST_R:    r_q    <= wr_val;
        DST_KRED: e_r0_q <= wr_val;
        DST_RN:   rn_q   <= wr_val;
        DST_XR:   xr_q   <= wr_val;
        DST_MM:   mm_q   <= wr_val;
        DST_S:    s_q    <= wr_val;
        DST_T:    t_q    <= wr_val;
        DST_LHS:  lhs_q  <= wr_val;
        DST_ACC:  acc_q  <= wr_val;
        default: ;
      endcase
    end
    case (cmd_i.op)
      OP_LOAD: begin
        msg_q <= msg_i;
        n_q   <= mod_q - WIDTH'(1);
      end
      OP_MUL: begin
        ma_q    <= a_val;
        mbits_q <= b_val;
        mmod_q  <= cmd_i.use_n ? n_q : mod_q;
        macc_q  <= '0;
        mdst_q  <= cmd_i.dst;
      end
      OP_DIV: begin
        dquo_q <= e_r0_q;
        drem_q <= '0;
      end
      OP_EXP_LOAD: begin
        acc_q  <= WIDTH'(1);
        base_q <= a_val;
        exp_q  <= b_val;
      end
      OP_EXP_SHIFT: exp_q <= {exp_q[OW-2:0], 1'b0};
      OP_EUC_INIT: begin
        e_r1_q <= n_q;
        e_s0_q <= (n_q == WIDTH'(1)) ? '0 : WIDTH'(1);
        e_s1_q <= '0;
      end
      OP_EUC_STEP: begin
        e_r0_q <= e_r1_q;
        e_r1_q <= drem_q;
        e_s0_q <= e_s1_q;
        e_s1_q <= sub_mod(e_s0_q, t_q, n_q);
      end
      OP_DIFF: diff_q <= sub_mod(mm_q, xr_q, n_q);
      OP_FAIL: begin
        s_q     <= '0;
        wval_q  <= 1'b0;
        wstat_q <= 1'b1;
      end
      OP_DEGEN: begin
        y_q     <= '0;
        r_q     <= '0;
        s_q     <= '0;
        wval_q  <= 1'b0;
        wstat_q <= 1'b1;
      end
      OP_CHECK: begin
        wval_q  <= (lhs_q == acc_q);
        wstat_q <= 1'b0;
      end
      OP_PUBLISH: begin
        oy_q    <= y_q;
        or_q    <= r_q;
        os_q    <= s_q;
        oval_q  <= wval_q;
        ostat_q <= wstat_q;
      end
      default: ;
    endcase
  end

  // status towards the controller
  always_comb begin
    sts_o.mul_busy = mb_q;
    sts_o.div_busy = db_q;
    sts_o.exp_msb  = exp_q[OW-1];
    sts_o.r1_zero  = (e_r1_q == '0);
    sts_o.r0_one   = (e_r0_q == WIDTH'(1));
    sts_o.p_small  = (mod_q < WIDTH'(2));
  end

  assign y_o      = oy_q;
  assign r_o      = or_q;
  assign s_o      = os_q;
  assign valid_o  = oval_q;
  assign status_o = ostat_q;

endmodule

// ===== rtl/egsv_ctrl.sv =====
// controller: sequences the exponentiations, the inverse and the check
`timescale 1ns / 1ps
`include "elgamal_sign_verify_assert.svh"
module egsv_ctrl import egsv_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  localparam int OW = (WIDTH > MSG_W) ? WIDTH : MSG_W;
  localparam int CW = $clog2(OW);

  typedef enum logic [3:0] {
    S_IDLE, S_STEP, S_MUL_WAIT, S_DIV_WAIT, S_POW_SQ, S_POW_SQW, S_POW_MUL,
    S_POW_MW, S_POW_SH, S_FINISH
  } state_e;

  typedef enum logic [4:0] {
    ST_GRED, ST_Y_INIT, ST_Y_SAVE, ST_R_INIT, ST_R_SAVE, ST_KRED, ST_EUC_INIT,
    ST_EUC_TEST, ST_EUC_MUL, ST_EUC_STEP, ST_INV_TEST, ST_RN, ST_XR, ST_MM,
    ST_DIFF, ST_S, ST_L1_INIT, ST_L1_SAVE, ST_L2_INIT, ST_LHS, ST_RHS_INIT,
    ST_CHECK
  } step_e;

  state_e        state_q, state_d;
  step_e         step_q, step_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ov_q, ov_d;

  // next state and datapath command
  always_comb begin
    cmd_o   = '{op: OP_NONE, a_sel: SRC_ONE, b_sel: SRC_ONE, use_n: 1'b0,
                dst: DST_ACC};
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_STEP;
          step_d   = ST_GRED;
        end
      end
      S_STEP: begin
        case (step_q)
          ST_GRED: begin
            if (sts_i.p_small) begin
              cmd_o.op = OP_DEGEN;
              state_d  = S_FINISH;
            end else begin
              cmd_o = '{op: OP_MUL, a_sel: SRC_ONE, b_sel: SRC_GEN, use_n: 1'b0,
                        dst: DST_GRED};
              state_d = S_MUL_WAIT;
              step_d  = ST_Y_INIT;
            end
          end
          ST_Y_INIT: begin
            cmd_o.op = OP_EXP_LOAD; cmd_o.a_sel = SRC_GRED; cmd_o.b_sel = SRC_KEY;
            cnt_d = '0; state_d = S_POW_SQ; step_d = ST_Y_SAVE;
          end
          ST_Y_SAVE: begin
            cmd_o.op = OP_COPY; cmd_o.dst = DST_Y; step_d = ST_R_INIT;
          end
          ST_R_INIT: begin
            cmd_o.op = OP_EXP_LOAD; cmd_o.a_sel = SRC_GRED; cmd_o.b_sel = SRC_NONCE;
            cnt_d = '0; state_d = S_POW_SQ; step_d = ST_R_SAVE;
          end
          ST_R_SAVE: begin
            cmd_o.op = OP_COPY; cmd_o.dst = DST_R; step_d = ST_KRED;
          end
          ST_KRED: begin
            cmd_o = '{op: OP_MUL, a_sel: SRC_ONE, b_sel: SRC_NONCE, use_n: 1'b1,
                      dst: DST_KRED};
            state_d = S_MUL_WAIT; step_d = ST_EUC_INIT;
          end
          ST_EUC_INIT: begin
            cmd_o.op = OP_EUC_INIT; step_d = ST_EUC_TEST;
          end
          ST_EUC_TEST: begin
            if (sts_i.r1_zero) begin
              step_d = ST_INV_TEST;
            end else begin
              cmd_o.op = OP_DIV; state_d = S_DIV_WAIT; step_d = ST_EUC_MUL;
            end
          end
          ST_EUC_MUL: begin
            cmd_o = '{op: OP_MUL, a_sel: SRC_S1, b_sel: SRC_Q, use_n: 1'b1,
                      dst: DST_T};
            state_d = S_MUL_WAIT; step_d = ST_EUC_STEP;
          end
          ST_EUC_STEP: begin
            cmd_o.op = OP_EUC_STEP; step_d = ST_EUC_TEST;
          end
          ST_INV_TEST: begin
            if (!sts_i.r0_one) begin
              cmd_o.op = OP_FAIL; state_d = S_FINISH;
            end else begin
              step_d = ST_RN;
            end
          end
          ST_RN: begin
            cmd_o = '{op: OP_MUL, a_sel: SRC_ONE, b_sel: SRC_R, use_n: 1'b1,
                      dst: DST_RN};
            state_d = S_MUL_WAIT; step_d = ST_XR;
          end
          ST_XR: begin
            cmd_o = '{op: OP_MUL, a_sel: SRC_RN, b_sel: SRC_KEY, use_n: 1'b1,
                      dst: DST_XR};
            state_d = S_MUL_WAIT; step_d = ST_MM;
          end
          ST_MM: begin
            cmd_o = '{op: OP_MUL, a_sel: SRC_ONE, b_sel: SRC_MSG, use_n: 1'b1,
                      dst: DST_MM};
            state_d = S_MUL_WAIT; step_d = ST_DIFF;
          end
          ST_DIFF: begin
            cmd_o.op = OP_DIFF; step_d = ST_S;
          end
          ST_S: begin
            cmd_o = '{op: OP_MUL, a_sel: SRC_DIFF, b_sel: SRC_S0, use_n: 1'b1,
                      dst: DST_S};
            state_d = S_MUL_WAIT; step_d = ST_L1_INIT;
          end
          ST_L1_INIT: begin
            cmd_o.op = OP_EXP_LOAD; cmd_o.a_sel = SRC_Y; cmd_o.b_sel = SRC_R;
            cnt_d = '0; state_d = S_POW_SQ; step_d = ST_L1_SAVE;
          end
          ST_L1_SAVE: begin
            cmd_o.op = OP_COPY; cmd_o.dst = DST_LHS; step_d = ST_L2_INIT;
          end
          ST_L2_INIT: begin
            cmd_o.op = OP_EXP_LOAD; cmd_o.a_sel = SRC_R; cmd_o.b_sel = SRC_S;
            cnt_d = '0; state_d = S_POW_SQ; step_d = ST_LHS;
          end
          ST_LHS: begin
            cmd_o = '{op: OP_MUL, a_sel: SRC_LHS, b_sel: SRC_ACC, use_n: 1'b0,
                      dst: DST_LHS};
            state_d = S_MUL_WAIT; step_d = ST_RHS_INIT;
          end
          ST_RHS_INIT: begin
            cmd_o.op = OP_EXP_LOAD; cmd_o.a_sel = SRC_GRED; cmd_o.b_sel = SRC_MSG;
            cnt_d = '0; state_d = S_POW_SQ; step_d = ST_CHECK;
          end
          ST_CHECK: begin
            cmd_o.op = OP_CHECK; state_d = S_FINISH;
          end
          default: step_d = ST_GRED;
        endcase
      end
      S_MUL_WAIT: if (!sts_i.mul_busy) state_d = S_STEP;
      S_DIV_WAIT: if (!sts_i.div_busy) state_d = S_STEP;
      // left-to-right square and multiply, one exponent bit per pass
      S_POW_SQ: begin
        cmd_o = '{op: OP_MUL, a_sel: SRC_ACC, b_sel: SRC_ACC, use_n: 1'b0,
                  dst: DST_ACC};
        state_d = S_POW_SQW;
      end
      S_POW_SQW: begin
        if (!sts_i.mul_busy) state_d = sts_i.exp_msb ? S_POW_MUL : S_POW_SH;
      end
      S_POW_MUL: begin
        cmd_o = '{op: OP_MUL, a_sel: SRC_BASE, b_sel: SRC_ACC, use_n: 1'b0,
                  dst: DST_ACC};
        state_d = S_POW_MW;
      end
      S_POW_MW: if (!sts_i.mul_busy) state_d = S_POW_SH;
      S_POW_SH: begin
        cmd_o.op = OP_EXP_SHIFT;
        cnt_d    = cnt_q + CW'(1);
        state_d  = (cnt_q == CW'(OW - 1)) ? S_STEP : S_POW_SQ;
      end
      S_FINISH: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.op = OP_PUBLISH;
          ov_d     = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= ST_GRED;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
      ov_q    <= ov_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  `EGSV_ASSERT(a_mul_free, (cmd_o.op == OP_MUL) |-> !sts_i.mul_busy, "product started while busy")
  `EGSV_ASSERT(a_div_free, (cmd_o.op == OP_DIV) |-> !sts_i.div_busy, "division started while busy")
  `EGSV_ASSERT(a_pub_shows, (cmd_o.op == OP_PUBLISH) |=> out_valid_o, "published result not shown")
  `EGSV_ASSERT_RST(a_rst_quiet, !rst_ni |-> !out_valid_o, "result shown during reset")

endmodule

// ===== rtl/elgamal_sign_verify.sv =====
// Each message runs through the bit-serial modular multiplier: each product holds the
// controller until it is done, each of the five exponentiations runs max(WIDTH,16)
// square-and-multiply rounds, and each euclid step adds a division and a product;
// a bad nonce or tiny modulus ends early. One message is handled at a time; the next is
// taken once its result is in the output register. Reset clears the controller and
// loads modulus 23, generator 5, key 3, nonce 5.
// top level of the elgamal signature generator and checker
`timescale 1ns / 1ps
module elgamal_sign_verify import egsv_pkg::*; #(
  parameter int WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [15:0]          s_axis_tdata,   // message
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // public_key, sig_r, sig_s, valid_res, status, zero fill
  output logic [55:0]          m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [WIDTH-1:0]     cfg_data_i
);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [WIDTH-1:0] y, r, s;
  logic             vld, stat;

  // controller
  egsv_ctrl #(.WIDTH(WIDTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  egsv_dpath #(.WIDTH(WIDTH)) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i),
    .cfg_idx_i (cfg_index_i),
    .cfg_data_i(cfg_data_i),
    .msg_i     (s_axis_tdata),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .y_o       (y),
    .r_o       (r),
    .s_o       (s),
    .valid_o   (vld),
    .status_o  (stat)
  );

  // configuration writes are always taken
  assign cfg_ready_o  = 1'b1;

  // result beat packing
  assign m_axis_tdata = {6'b0, stat, vld, OUT_W'(s), OUT_W'(r), OUT_W'(y)};

endmodule
